FILE: rtl/ipv4bl_pkg.sv
package ipv4bl_pkg;

  localparam int ADDR_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;

  // what one slot read back says about the key under search
  typedef struct packed {
    logic used;
    logic match;
  } slot_stat_t;

endpackage

FILE: rtl/ipv4bl_store.sv
module ipv4bl_store #(
  parameter int DEPTH = 64,
  parameter int IW = 6
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IW-1:0]                  wr_idx,
  input  logic                           wr_used,
  input  logic [ipv4bl_pkg::ADDR_W-1:0] wr_addr,
  input  logic [IW-1:0]                  rd_idx,
  input  logic [ipv4bl_pkg::ADDR_W-1:0] key,
  output ipv4bl_pkg::slot_stat_t         stat
);
  import ipv4bl_pkg::*;

  // each word is {used, address}
  logic [ADDR_W:0] mem [DEPTH];
  logic [ADDR_W:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_used, wr_addr};
    end
    rd_word <= mem[rd_idx];
  end

  always_comb begin
    stat.used = rd_word[ADDR_W];
    stat.match = rd_word[ADDR_W] && (rd_word[ADDR_W-1:0] == key);
  end

endmodule

FILE: rtl/ipv4_source_blocklist_table_top.sv
// an accepted transaction goes from idle through the search to done, where the
//   result is registered; a packet check of address zero or an unused operation
//   skips the search. One transaction is in flight at a time: no new one is taken
//   until its result is loaded. The search is bound by the single read port of the
//   slot memory, which it walks one slot a cycle; a result held by the receiver stalls done
// reset: a clearing pass over the table marks every slot free; no
//   transaction is taken until it ends
module ipv4_source_blocklist_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic [ipv4bl_pkg::OP_W-1:0]     operation,
  input  logic [ipv4bl_pkg::ADDR_W-1:0]   address,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [ipv4bl_pkg::STATUS_W-1:0] status,
  output logic                             drop
);
  import ipv4bl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_C = CW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [CW-1:0] scan_cnt;
  logic rd_pend;
  logic [IW-1:0] rd_slot;
  logic [OP_W-1:0] cur_op;
  logic [ADDR_W-1:0] cur_addr;
  logic hit;
  logic [IW-1:0] hit_idx;
  logic free_found;
  logic [IW-1:0] free_idx;

  logic in_range;
  logic [IW-1:0] rd_idx;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic wr_used;
  logic out_free;
  logic [STATUS_W-1:0] status_next;
  logic drop_next;
  slot_stat_t stat;

  assign item_ready = (state == S_IDLE);
  assign in_range = (scan_cnt < DEPTH_C);
  assign rd_idx = in_range ? scan_cnt[IW-1:0] : '0;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (scan_cnt == LAST_C) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          // zero source checks and unused codes need no search
          if ((operation == OP_CHECK && address == '0) ||
              (operation != OP_CHECK && operation != OP_ADD && operation != OP_REMOVE)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!in_range && !rd_pend) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    status_next = ST_NOT_FOUND;
    drop_next = 1'b0;
    case (cur_op)
      OP_CHECK: begin
        status_next = hit ? ST_FOUND : ST_NOT_FOUND;
        drop_next = hit;
      end
      OP_ADD: begin
        if (hit) status_next = ST_PRESENT;
        else if (free_found) status_next = ST_ADDED;
        else status_next = ST_FULL;
      end
      OP_REMOVE: begin
        status_next = hit ? ST_REMOVED : ST_NOT_FOUND;
      end
      default: status_next = ST_NOT_FOUND;
    endcase
  end

  // writes happen only outside the search, so no read can see a stale slot
  always_comb begin
    wr_en = 1'b0;
    wr_idx = rd_idx;
    wr_used = 1'b0;
    if (state == S_CLEAR) begin
      wr_en = in_range;
    end else if (state == S_DONE && out_free) begin
      if (cur_op == OP_ADD && !hit && free_found) begin
        wr_en = 1'b1;
        wr_idx = free_idx;
        wr_used = 1'b1;
      end else if (cur_op == OP_REMOVE && hit) begin
        wr_en = 1'b1;
        wr_idx = hit_idx;
      end
    end
  end

  ipv4bl_store #(
    .DEPTH(TABLE_DEPTH),
    .IW(IW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_idx(wr_idx),
    .wr_used(wr_used),
    .wr_addr(cur_addr),
    .rd_idx(rd_idx),
    .key(cur_addr),
    .stat(stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan_cnt <= '0;
      rd_pend <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          scan_cnt <= (scan_cnt == LAST_C) ? '0 : scan_cnt + 1'b1;
        end
        S_IDLE: begin
          scan_cnt <= '0;
          rd_pend <= 1'b0;
          hit <= 1'b0;
          free_found <= 1'b0;
        end
        S_SCAN: begin
          if (in_range) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (stat.match && !hit) hit <= 1'b1;
            if (!stat.used && !free_found) free_found <= 1'b1;
          end
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cur_op <= operation;
      cur_addr <= address;
    end
    rd_slot <= rd_idx;
    if (state == S_SCAN && rd_pend) begin
      if (stat.match && !hit) hit_idx <= rd_slot;
      if (!stat.used && !free_found) free_idx <= rd_slot;
    end
    if (state == S_DONE && out_free) begin
      status <= status_next;
      drop <= drop_next;
    end
  end

  a_drop_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && drop |-> status == ST_FOUND)
    else $error("drop without found status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready held after accepted transaction");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_CLEAR || state == S_DONE)
    else $error("slot write during search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    scan_cnt <= DEPTH_C)
    else $error("search counter out of range");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> state == S_IDLE && result_valid)
    else $error("result not loaded at end of search");

endmodule

FILE: dv/ipv4_source_blocklist_table_checker.sv
module ipv4_source_blocklist_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  logic [ipv4bl_pkg::OP_W-1:0]     operation,
  input  logic [ipv4bl_pkg::ADDR_W-1:0]   address,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic [ipv4bl_pkg::STATUS_W-1:0] status,
  input  logic                            drop,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ipv4bl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                drop;
  } verdict_t;

  logic [ADDR_W-1:0] blocked_addr [TABLE_DEPTH];
  logic              blocked_used [TABLE_DEPTH];
  verdict_t          expected_verdicts [$];
  int                mismatch_count = 0;

  // applies one transaction to the shadow table and returns what the block must answer
  function automatic verdict_t apply_table_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    verdict_t v;
    int hit;
    int spare;
    v.status = ST_NOT_FOUND;
    v.drop = 1'b0;
    hit = -1;
    spare = -1;
    // walk downward so the lowest free slot wins
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (blocked_used[i] && blocked_addr[i] == addr) hit = i;
      if (!blocked_used[i]) spare = i;
    end
    case (op)
      OP_CHECK: begin
        if (addr != '0 && hit >= 0) begin
          v.status = ST_FOUND;
          v.drop = 1'b1;
        end
      end
      OP_ADD: begin
        if (hit >= 0) begin
          v.status = ST_PRESENT;
        end else if (spare < 0) begin
          v.status = ST_FULL;
        end else begin
          blocked_addr[spare] = addr;
          blocked_used[spare] = 1'b1;
          v.status = ST_ADDED;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          blocked_used[hit] = 1'b0;
          v.status = ST_REMOVED;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) blocked_used[i] = 1'b0;
      expected_verdicts.delete();
    end else begin
      // the result side goes first: a result never belongs to a transaction of the same edge
      if (result_valid && result_ready) begin
        got.status = status;
        got.drop = drop;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d drop %0b",
                   $time, got.status, got.drop);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.drop !== want.drop) begin
            $display("%0t: drop mismatch, expected %0b, actual %0b",
                     $time, want.drop, got.drop);
            mismatch_count++;
          end
        end
      end
      if (item_valid && item_ready) begin
        expected_verdicts.push_back(apply_table_op(operation, address));
      end
    end
    mismatches <= mismatch_count;
    outstanding <= expected_verdicts.size();
  end

endmodule

FILE: dv/ipv4_source_blocklist_table_top_test.sv
module ipv4_source_blocklist_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipv4bl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 80;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_LEN = 250;
  localparam int QUIET_ITEMS = 150;
  localparam int LONG_HOLD = 600;
  localparam int STALL_LIMIT = 5000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [OP_W-1:0]     operation = '0;
  logic [ADDR_W-1:0]   address = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                drop;
  int                  mismatches;
  int                  outstanding;

  int                  sent = 0;
  bit                  quiet = 1'b0;
  logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];

  ipv4_source_blocklist_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .operation(operation),
    .address(address),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status(status),
    .drop(drop)
  );

  ipv4_source_blocklist_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .operation(operation),
    .address(address),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status(status),
    .drop(drop),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    address <= addr;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_table_results();
    item_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  initial begin
    int roll;
    int phase;
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] addr;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, address zero, extremes, slot reuse, unused code
    offer(OP_CHECK, 32'h0000_0000);
    offer(OP_CHECK, 32'hFFFF_FFFF);
    offer(OP_REMOVE, 32'h1234_5678);
    offer(OP_ADD, 32'h0000_0000);
    offer(OP_CHECK, 32'h0000_0000);
    offer(OP_ADD, 32'h0000_0000);
    offer(OP_ADD, 32'hFFFF_FFFF);
    offer(OP_CHECK, 32'hFFFF_FFFF);
    offer(OP_CHECK, 32'hFFFF_FFFE);
    offer(OP_CHECK, 32'h7FFF_FFFF);
    offer(OP_ADD, 32'h8000_0000);
    offer(OP_ADD, 32'h0000_0001);
    offer(OP_REMOVE, 32'hFFFF_FFFF);
    offer(OP_CHECK, 32'hFFFF_FFFF);
    offer(OP_ADD, 32'hA5A5_A5A5);
    offer(OP_REMOVE, 32'h0000_0000);
    offer(OP_REMOVE, 32'h0000_0000);
    offer(OP_UNUSED, 32'hFFFF_FFFF);
    offer(OP_UNUSED, 32'h0000_0000);
    offer(OP_CHECK, 32'h8000_0000);
    offer(OP_CHECK, 32'h0000_0001);
    offer(OP_ADD, 32'h5A5A_5A5A);
    drain_table_results();

    // random: phases that fill the table past full, mix, and drain it
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == RANDOM_ITEMS / 2) drain_table_results();
      phase = (n / PHASE_LEN) % 3;
      roll = $urandom_range(0, 99);
      case (phase)
        0: op = (roll < 70) ? OP_ADD : (roll < 90) ? OP_CHECK : OP_REMOVE;
        1: op = (roll < 34) ? OP_ADD : (roll < 67) ? OP_CHECK : OP_REMOVE;
        default: op = (roll < 20) ? OP_ADD : (roll < 40) ? OP_CHECK : OP_REMOVE;
      endcase
      if ($urandom_range(0, 99) == 0) op = OP_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 95) begin
        // near miss of a pooled address
        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        addr = $urandom;
      end
      offer(op, addr);
    end

    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (TABLE_DEPTH + 10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: short random stalls, one long hold-off to back the block up
  initial begin
    bit long_done;
    long_done = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_done && sent >= 500) begin
        long_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  // ends the run when no transaction moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ipv4bl_pkg.sv
rtl/ipv4bl_store.sv
rtl/ipv4_source_blocklist_table_top.sv
dv/ipv4_source_blocklist_table_checker.sv
dv/ipv4_source_blocklist_table_top_test.sv
